[hw/rtl/ratm_pkg.sv]
// ----------------------------------------------------------------------------
// RTC alarm table matcher package
// Shared field types, command codes and the command broadcast to the slot row.
// ----------------------------------------------------------------------------
package ratm_pkg;

  // Field types
  typedef logic [2:0]  opcode_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;
  typedef logic [11:0] year_t;
  typedef logic [3:0]  slot_t;

  // Width of the per-slot fired vector on the result port
  localparam int unsigned FIRED_W = 8;

  // Reset value of the minimum valid year register
  localparam year_t MIN_YEAR_RST = 12'd2025;

  // Command codes
  localparam opcode_t OP_TICK    = 3'd0;
  localparam opcode_t OP_ADD     = 3'd1;
  localparam opcode_t OP_REMOVE  = 3'd2;
  localparam opcode_t OP_ENABLE  = 3'd3;
  localparam opcode_t OP_DISABLE = 3'd4;
  localparam opcode_t OP_CLEAR   = 3'd5;

  // Command broadcast from the top level to every slot cell
  typedef struct packed {
    logic    valid;
    opcode_t op;
    hour_t   hour;
    minute_t minute;
    logic    sec_zero;
    logic    tick_ok;
    slot_t   slot;
  } cmd_t;

  // Per-cell result of one command
  typedef struct packed {
    logic fire;
    logic take;
  } cell_out_t;

endpackage

[hw/rtl/ratm_slot_cell.sv]
// ----------------------------------------------------------------------------
// RTC alarm slot cell
// Holds one alarm slot and executes each broadcast command on it. A claim bit
// ripples along the row so that an add lands in the lowest free slot.
// ----------------------------------------------------------------------------
module ratm_slot_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ratm_pkg::cmd_t      cmd_i,
  input  logic                claim_i,
  output logic                claim_o,
  output ratm_pkg::cell_out_t res_o
);

  localparam ratm_pkg::slot_t MyIdx = ratm_pkg::slot_t'(Idx);

  logic              en_q, en_d;
  logic              lat_q, lat_d;
  ratm_pkg::hour_t   hour_q, hour_d;
  ratm_pkg::minute_t min_q, min_d;

  logic hit;
  logic sel;
  logic take;
  logic fire;

  // Time compare and addressing
  assign hit  = (cmd_i.hour == hour_q) && (cmd_i.minute == min_q) && cmd_i.sec_zero;
  assign sel  = (cmd_i.slot == MyIdx);
  assign take = cmd_i.valid && (cmd_i.op == ratm_pkg::OP_ADD) && !claim_i && !en_q;

  // A free slot claims the add for everything after it
  assign claim_o = claim_i || !en_q;

  // Next state of the slot
  always_comb begin
    en_d   = en_q;
    lat_d  = lat_q;
    hour_d = hour_q;
    min_d  = min_q;
    fire   = 1'b0;
    if (cmd_i.valid) begin
      case (cmd_i.op) inside
        ratm_pkg::OP_TICK: begin
          if (cmd_i.tick_ok && en_q) begin
            if (hit) begin
              lat_d = 1'b1;
              fire  = !lat_q;
            end else begin
              lat_d = 1'b0;
            end
          end
        end
        ratm_pkg::OP_ADD: begin
          if (take) begin
            en_d   = 1'b1;
            lat_d  = 1'b0;
            hour_d = cmd_i.hour;
            min_d  = cmd_i.minute;
          end
        end
        ratm_pkg::OP_REMOVE, ratm_pkg::OP_DISABLE: begin
          if (sel) begin
            en_d = 1'b0;
          end
        end
        ratm_pkg::OP_ENABLE: begin
          if (sel) begin
            en_d  = 1'b1;
            lat_d = 1'b0;
          end
        end
        ratm_pkg::OP_CLEAR: begin
          en_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Slot state registers; the stored time resets to 00:00
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      lat_q  <= 1'b0;
      hour_q <= '0;
      min_q  <= '0;
    end else begin
      en_q   <= en_d;
      lat_q  <= lat_d;
      hour_q <= hour_d;
      min_q  <= min_d;
    end
  end

  assign res_o.fire = fire;
  assign res_o.take = take;

endmodule

[hw/rtl/rtc_alarm_table_matcher_unit.sv]
// ----------------------------------------------------------------------------
// RTC alarm table matcher
// Row of alarm slot cells matched against time samples, plus midnight event.
// The result strobe is registered and rises in the cycle after the command is taken.
// Throughput: one command per cycle; busy stays low and results cannot be
// stalled, the slot row finishes each command in the cycle it arrives.
// Reset: all slots disabled at 00:00 with latches clear, min year 2025.
// ----------------------------------------------------------------------------
module rtc_alarm_table_matcher_unit #(
  parameter int unsigned NUM_ALARMS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ratm_pkg::opcode_t            opcode_i,
  input  ratm_pkg::hour_t              hour_i,
  input  ratm_pkg::minute_t            minute_i,
  input  ratm_pkg::second_t            second_i,
  input  ratm_pkg::year_t              year_i,
  input  ratm_pkg::slot_t              slot_i,
  input  logic                         cfg_we_i,
  input  ratm_pkg::year_t              cfg_wdata_i,
  output logic                         done_o,
  output logic [ratm_pkg::FIRED_W-1:0] alarm_fired_o,
  output logic                         midnight_fired_o,
  output ratm_pkg::slot_t              added_slot_o,
  output logic                         add_failed_o
);

  ratm_pkg::year_t     min_year_q;
  ratm_pkg::cmd_t      cmd;
  logic                accept;
  logic                mid_lat_q, mid_lat_d;
  logic                mid_fire;
  logic                is_midnight;

  logic                [NUM_ALARMS:0] claim;
  ratm_pkg::cell_out_t [NUM_ALARMS-1:0] cell_res;

  logic [ratm_pkg::FIRED_W-1:0] fired;
  ratm_pkg::slot_t              added;
  logic                         failed;

  // Commands are taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= ratm_pkg::MIN_YEAR_RST;
    end else if (cfg_we_i) begin
      min_year_q <= cfg_wdata_i;
    end
  end

  // Command broadcast to the slot row
  always_comb begin
    cmd.valid    = accept;
    cmd.op       = opcode_i;
    cmd.hour     = hour_i;
    cmd.minute   = minute_i;
    cmd.sec_zero = (second_i == '0);
    cmd.tick_ok  = (year_i >= min_year_q);
    cmd.slot     = slot_i;
  end

  // Midnight event with its own latch
  assign is_midnight = (hour_i == '0) && (minute_i == '0) && (second_i == '0);

  always_comb begin
    mid_lat_d = mid_lat_q;
    mid_fire  = 1'b0;
    if (accept && (opcode_i == ratm_pkg::OP_TICK) && cmd.tick_ok) begin
      if (is_midnight) begin
        mid_lat_d = 1'b1;
        mid_fire  = !mid_lat_q;
      end else begin
        mid_lat_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_lat_q <= 1'b0;
    end else begin
      mid_lat_q <= mid_lat_d;
    end
  end

  // Row of slot cells with the free-slot claim chain
  assign claim[0] = 1'b0;

  for (genvar g = 0; g < NUM_ALARMS; g++) begin : g_cell
    ratm_slot_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .claim_i(claim[g]),
      .claim_o(claim[g+1]),
      .res_o  (cell_res[g])
    );
  end

  // Fired vector: slots beyond the port width have no bit
  for (genvar g = 0; g < ratm_pkg::FIRED_W; g++) begin : g_fired
    if (g < NUM_ALARMS) begin : g_on
      assign fired[g] = cell_res[g].fire;
    end else begin : g_off
      assign fired[g] = 1'b0;
    end
  end

  // Encode the slot that took an add transaction
  always_comb begin
    added = '0;
    for (int unsigned i = 0; i < NUM_ALARMS; i++) begin
      if (cell_res[i].take) begin
        added = added | ratm_pkg::slot_t'(i);
      end
    end
  end

  assign failed = accept && (opcode_i == ratm_pkg::OP_ADD) && !claim[NUM_ALARMS];

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    alarm_fired_o    <= fired;
    midnight_fired_o <= mid_fire;
    added_slot_o     <= added;
    add_failed_o     <= failed;
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// RTC alarm table matcher testbench
// Drives tick and table commands into the matcher and checks every result
// strobe against a cycle-free model of the alarm table kept in this bench.
// A directed table covers reset state, extremes, a full table and reserved
// codes. Random phases follow, each after a new write of the minimum valid year.
// ----------------------------------------------------------------------------
module tb;
  import ratm_pkg::*;

  localparam int unsigned NUM_SLOTS    = 8;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DIR_ROWS     = 26;

  // Codes with no function; the block must ignore them.
  localparam opcode_t OP_RSVD6 = 3'd6;
  localparam opcode_t OP_RSVD7 = 3'd7;

  // One result transaction.
  typedef struct packed {
    logic [FIRED_W-1:0] fired;
    logic               mid;
    slot_t              added;
    logic               failed;
  } alarm_result_t;

  localparam alarm_result_t NO_EVENT = '0;

  // One row of the directed stimulus table.
  typedef struct packed {
    opcode_t       op;
    hour_t         hr;
    minute_t       mn;
    second_t       sc;
    year_t         yr;
    slot_t         sl;
    logic          known;
    alarm_result_t result;
  } dir_row_t;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  opcode_t       opcode_i = OP_TICK;
  hour_t         hour_i = '0;
  minute_t       minute_i = '0;
  second_t       second_i = '0;
  year_t         year_i = '0;
  slot_t         slot_i = '0;
  logic          cfg_we_i = 1'b0;
  year_t         cfg_wdata_i = '0;
  logic          done_o;
  logic [FIRED_W-1:0] alarm_fired_o;
  logic          midnight_fired_o;
  slot_t         added_slot_o;
  logic          add_failed_o;

  // Typed expectation that travels with a directed command.
  logic          row_known = 1'b0;
  alarm_result_t row_expect = NO_EVENT;

  // Alarm table model state.
  logic [NUM_SLOTS-1:0] slot_armed = '0;
  logic [NUM_SLOTS-1:0] slot_held = '0;
  hour_t                slot_hour_tbl [NUM_SLOTS];
  minute_t              slot_minute_tbl [NUM_SLOTS];
  logic                 midnight_held = 1'b0;
  year_t                valid_year_floor = MIN_YEAR_RST;

  alarm_result_t expected_results [$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;

  // Last tick time, reused so that latches see repeated matches.
  hour_t   last_hr = '0;
  minute_t last_mn = '0;
  second_t last_sc = '0;

  // Directed rows; the expected result is typed in only where it is obvious.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_ENABLE, 5'd0,  6'd0,  6'd0,  12'd0,    4'd7,  1'b0, NO_EVENT},
    '{OP_TICK,   5'd0,  6'd0,  6'd0,  12'd2025, 4'd0,  1'b1,
      '{8'h80, 1'b1, 4'd0, 1'b0}},
    '{OP_TICK,   5'd0,  6'd0,  6'd0,  12'd2025, 4'd0,  1'b1, NO_EVENT},
    '{OP_TICK,   5'd23, 6'd59, 6'd59, 12'd4095, 4'd0,  1'b0, NO_EVENT},
    '{OP_TICK,   5'd0,  6'd0,  6'd0,  12'd2024, 4'd0,  1'b1, NO_EVENT},
    '{OP_TICK,   5'd0,  6'd0,  6'd0,  12'd2025, 4'd0,  1'b1,
      '{8'h80, 1'b1, 4'd0, 1'b0}},
    '{OP_ADD,    5'd12, 6'd30, 6'd0,  12'd0,    4'd0,  1'b1, NO_EVENT},
    '{OP_ADD,    5'd31, 6'd63, 6'd63, 12'd4095, 4'd15, 1'b1,
      '{8'h00, 1'b0, 4'd1, 1'b0}},
    '{OP_ADD,    5'd0,  6'd0,  6'd0,  12'd0,    4'd0,  1'b0, NO_EVENT},
    '{OP_ADD,    5'd23, 6'd59, 6'd0,  12'd0,    4'd0,  1'b0, NO_EVENT},
    '{OP_ADD,    5'd12, 6'd30, 6'd0,  12'd0,    4'd0,  1'b0, NO_EVENT},
    '{OP_ADD,    5'd1,  6'd1,  6'd0,  12'd0,    4'd0,  1'b0, NO_EVENT},
    '{OP_ADD,    5'd2,  6'd2,  6'd0,  12'd0,    4'd0,  1'b0, NO_EVENT},
    '{OP_ADD,    5'd5,  6'd5,  6'd0,  12'd0,    4'd0,  1'b1,
      '{8'h00, 1'b0, 4'd0, 1'b1}},
    '{OP_TICK,   5'd12, 6'd30, 6'd0,  12'd2025, 4'd0,  1'b0, NO_EVENT},
    '{OP_TICK,   5'd12, 6'd30, 6'd0,  12'd2025, 4'd0,  1'b0, NO_EVENT},
    '{OP_TICK,   5'd31, 6'd63, 6'd0,  12'd2025, 4'd0,  1'b0, NO_EVENT},
    '{OP_REMOVE, 5'd0,  6'd0,  6'd0,  12'd0,    4'd4,  1'b0, NO_EVENT},
    '{OP_DISABLE,5'd0,  6'd0,  6'd0,  12'd0,    4'd15, 1'b1, NO_EVENT},
    '{OP_RSVD6,  5'd0,  6'd0,  6'd0,  12'd4095, 4'd0,  1'b1, NO_EVENT},
    '{OP_RSVD7,  5'd0,  6'd0,  6'd0,  12'd4095, 4'd3,  1'b1, NO_EVENT},
    '{OP_ENABLE, 5'd0,  6'd0,  6'd0,  12'd0,    4'd4,  1'b0, NO_EVENT},
    '{OP_TICK,   5'd12, 6'd30, 6'd0,  12'd4095, 4'd0,  1'b0, NO_EVENT},
    '{OP_TICK,   5'd0,  6'd0,  6'd0,  12'd2025, 4'd0,  1'b0, NO_EVENT},
    '{OP_CLEAR,  5'd0,  6'd0,  6'd0,  12'd0,    4'd0,  1'b0, NO_EVENT},
    '{OP_TICK,   5'd0,  6'd0,  6'd0,  12'd2025, 4'd0,  1'b0, NO_EVENT}
  };

  rtc_alarm_table_matcher_unit #(
    .NUM_ALARMS(NUM_SLOTS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .hour_i           (hour_i),
    .minute_i         (minute_i),
    .second_i         (second_i),
    .year_i           (year_i),
    .slot_i           (slot_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .alarm_fired_o    (alarm_fired_o),
    .midnight_fired_o (midnight_fired_o),
    .added_slot_o     (added_slot_o),
    .add_failed_o     (add_failed_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one command to the alarm table model and returns its result.
  function automatic alarm_result_t alarm_table_step(opcode_t op, hour_t hr, minute_t mn,
                                                     second_t sc, year_t yr, slot_t sl);
    alarm_result_t res;
    bit            found;
    res   = NO_EVENT;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        if (yr >= valid_year_floor) begin
          if (hr == '0 && mn == '0 && sc == '0) begin
            if (!midnight_held) begin
              midnight_held = 1'b1;
              res.mid       = 1'b1;
            end
          end else begin
            midnight_held = 1'b0;
          end
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_armed[i]) begin
              if (hr == slot_hour_tbl[i] && mn == slot_minute_tbl[i] && sc == '0) begin
                if (!slot_held[i]) begin
                  slot_held[i] = 1'b1;
                  if (i < FIRED_W) res.fired[i] = 1'b1;
                end
              end else begin
                slot_held[i] = 1'b0;
              end
            end
          end
        end
      end
      OP_ADD: begin
        res.failed = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !slot_armed[i]) begin
            slot_armed[i]      = 1'b1;
            slot_hour_tbl[i]   = hr;
            slot_minute_tbl[i] = mn;
            slot_held[i]       = 1'b0;
            res.added          = slot_t'(i);
            res.failed         = 1'b0;
            found              = 1'b1;
          end
        end
      end
      OP_REMOVE, OP_DISABLE: begin
        if (sl < NUM_SLOTS) slot_armed[sl] = 1'b0;
      end
      OP_ENABLE: begin
        if (sl < NUM_SLOTS) begin
          slot_armed[sl] = 1'b1;
          slot_held[sl]  = 1'b0;
        end
      end
      OP_CLEAR: begin
        slot_armed = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Reports one result field that differs from its expectation.
  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Records the expectation of each accepted command, then checks each result strobe.
  always @(posedge clk_i) begin : result_check
    alarm_result_t pred;
    alarm_result_t exp_res;
    if (rst_ni) begin
      if (start && !busy) begin
        pred = alarm_table_step(opcode_i, hour_i, minute_i, second_i, year_i, slot_i);
        expected_results.push_back(row_known ? row_expect : pred);
      end
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no command outstanding: fired %0h midnight %0b",
                   $time, alarm_fired_o, midnight_fired_o);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("alarm_fired", exp_res.fired, alarm_fired_o);
          check_field("midnight_fired", 8'(exp_res.mid), 8'(midnight_fired_o));
          check_field("added_slot", 8'(exp_res.added), 8'(added_slot_o));
          check_field("add_failed", 8'(exp_res.failed), 8'(add_failed_o));
        end
      end
    end
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[rtc_alarm_table_matcher_unit] ERROR");
      $finish;
    end
  end

  // Presents one command and holds it until the transaction is taken.
  task automatic send_command(opcode_t op, hour_t hr, minute_t mn, second_t sc, year_t yr,
                              slot_t sl, logic known, alarm_result_t res);
    opcode_i   <= op;
    hour_i     <= hr;
    minute_i   <= mn;
    second_i   <= sc;
    year_i     <= yr;
    slot_i     <= sl;
    row_known  <= known;
    row_expect <= res;
    start      <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender gap of a random length.
  task automatic idle_burst();
    int unsigned n;
    n = $urandom_range(1, 10);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Holds off new commands until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes the minimum valid year while the block is idle.
  task automatic write_min_year(year_t value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    valid_year_floor = value;
  endtask

  // Random commands, weighted toward ticks that hit stored alarm times.
  task automatic run_random(int unsigned count, bit with_gaps);
    opcode_t     op;
    hour_t       hr;
    minute_t     mn;
    second_t     sc;
    year_t       yr;
    slot_t       sl;
    int unsigned pick;
    int unsigned k;
    int unsigned idx;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      hr   = hour_t'($urandom);
      mn   = minute_t'($urandom);
      sc   = second_t'($urandom);
      yr   = year_t'($urandom);
      sl   = slot_t'($urandom);
      if (pick < 45) begin
        op = OP_TICK;
        k  = $urandom_range(0, 99);
        if (k < 35) begin
          idx = $urandom_range(0, NUM_SLOTS - 1);
          hr  = slot_hour_tbl[idx];
          mn  = slot_minute_tbl[idx];
          if ($urandom_range(0, 3) != 0) sc = '0;
        end else if (k < 50) begin
          hr = last_hr;
          mn = last_mn;
          sc = last_sc;
        end else if (k < 60) begin
          hr = '0;
          mn = '0;
          if ($urandom_range(0, 3) != 0) sc = '0;
        end else if (k < 85) begin
          hr = hour_t'($urandom_range(0, 23));
          mn = minute_t'($urandom_range(0, 59));
          sc = second_t'($urandom_range(0, 59));
        end
        if ($urandom_range(0, 3) != 0) yr = year_t'($urandom_range(valid_year_floor, 4095));
        last_hr = hr;
        last_mn = mn;
        last_sc = sc;
      end else if (pick < 60) begin
        op = OP_ADD;
        if ($urandom_range(0, 5) != 0) begin
          hr = hour_t'($urandom_range(0, 23));
          mn = minute_t'($urandom_range(0, 59));
        end
      end else if (pick < 70) begin
        op = OP_REMOVE;
      end else if (pick < 80) begin
        op = OP_ENABLE;
      end else if (pick < 90) begin
        op = OP_DISABLE;
      end else if (pick < 95) begin
        op = OP_CLEAR;
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
      end
      // Keep most slot targets inside the table.
      if ($urandom_range(0, 4) != 0) sl = slot_t'($urandom_range(0, NUM_SLOTS - 1));
      send_command(op, hr, mn, sc, yr, sl, 1'b0, NO_EVENT);
      if (with_gaps && $urandom_range(0, 4) == 0) idle_burst();
    end
  endtask

  // Test sequence.
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_hour_tbl[i]   = '0;
      slot_minute_tbl[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset value of the year threshold.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_command(dir_rows[i].op, dir_rows[i].hr, dir_rows[i].mn, dir_rows[i].sc,
                   dir_rows[i].yr, dir_rows[i].sl, dir_rows[i].known, dir_rows[i].result);
      if (i % 7 == 6) idle_burst();
    end

    // Random phases, each after a threshold write; the last runs without gaps.
    write_min_year(12'd0);
    run_random(PHASE_ITEMS, 1'b1);
    write_min_year(12'd4095);
    run_random(PHASE_ITEMS, 1'b1);
    write_min_year(year_t'($urandom_range(1, 4094)));
    run_random(PHASE_ITEMS, 1'b1);
    write_min_year(MIN_YEAR_RST);
    run_random(PHASE_ITEMS, 1'b0);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[rtc_alarm_table_matcher_unit] OK");
    end else begin
      $display("[rtc_alarm_table_matcher_unit] ERROR");
    end
    $finish;
  end

endmodule
